### rtl/core/pfe_pkg.sv
package pfe_pkg;

  // Input command codes
  localparam logic [1:0] CmdFormat  = 2'd0;
  localparam logic [1:0] CmdStrByte = 2'd1;
  localparam logic [1:0] CmdStrEnd  = 2'd2;
  localparam logic [1:0] CmdStrNull = 2'd3;

  // Characters with a meaning in the format
  localparam logic [7:0] ChrPercent = 8'h25;
  localparam logic [7:0] ChrMinus   = 8'h2d;
  localparam logic [7:0] ChrLowD    = 8'h64;
  localparam logic [7:0] ChrLowX    = 8'h78;
  localparam logic [7:0] ChrLowS    = 8'h73;

  // Digit, character and bit counts
  localparam int unsigned DecDigits = 10;
  localparam int unsigned HexDigits = 8;
  localparam int unsigned NullChars = 6;
  localparam int unsigned NumBits   = 32;

  // Lowercase hex digit, also serves decimal digits 0..9
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h62;
      4'd12:   c = 8'h63;
      4'd13:   c = 8'h64;
      4'd14:   c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

  // "(null)" indexed by characters remaining after this one
  function automatic logic [7:0] null_char(input logic [2:0] rem);
    logic [7:0] c;
    case (rem)
      3'd5:    c = 8'h28;
      3'd4:    c = 8'h6e;
      3'd3:    c = 8'h75;
      3'd2:    c = 8'h6c;
      3'd1:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/print_format_engine.sv
// Output: a plain byte, string byte or unknown directive shows its character in the
// cycle after acceptance. %x emits one nibble per cycle and "(null)" one character
// per cycle while the output is not stalled; %d runs a bit-serial binary-to-BCD pass
// over the 32 magnitude bits and then emits ten digits like %x. Leading zeros print
// nothing. Throughput: one item at a time; the next item waits for the last character.
// Reset (rst_ni low, asynchronous): no pending '%', string mode off, count 0.
module print_format_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic [7:0]         data_byte_i,
  input  logic signed [31:0] number_i,
  input  logic               final_format_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_char_o,
  output logic               run_last_o,
  output logic [30:0]        total_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DIGIT,
    ST_NULL
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] mag_q, mag_d;
  logic [39:0] digits_q, digits_d;
  logic        started_q, started_d;
  logic        pending_q, pending_d;
  logic        smode_q, smode_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_char_q;
  logic        out_last_q;
  logic [30:0] total_q;

  logic        out_free, accept;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;
  logic [39:0] bcd_adj;
  logic [3:0]  top_dig;
  logic        show_dig;
  logic [31:0] num_mag;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign num_mag  = number_i[31] ? (32'd0 - number_i) : number_i;
  assign top_dig  = digits_q[39:36];
  assign show_dig = (top_dig != 4'd0) || started_q || (cnt_q == 5'd0);

  // Add-3 correction per BCD digit before each shift
  always_comb begin
    for (int i = 0; i < pfe_pkg::DecDigits; i++) begin
      bcd_adj[i*4 +: 4] = (digits_q[i*4 +: 4] >= 4'd5) ?
                          (digits_q[i*4 +: 4] + 4'd3) : digits_q[i*4 +: 4];
    end
  end

  // Next state and character emission
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    mag_d     = mag_q;
    digits_d  = digits_q;
    started_d = started_q;
    pending_d = pending_q;
    smode_d   = smode_q;
    emit      = 1'b0;
    emit_char = data_byte_i;
    emit_last = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            pfe_pkg::CmdFormat: begin
              smode_d = 1'b0;
              if (pending_q) begin
                pending_d = 1'b0;
                if (data_byte_i == pfe_pkg::ChrLowD) begin
                  mag_d     = num_mag;
                  digits_d  = '0;
                  cnt_d     = '0;
                  state_d   = ST_CONV;
                  emit      = number_i[31];
                  emit_char = pfe_pkg::ChrMinus;
                  emit_last = 1'b0;
                end else if (data_byte_i == pfe_pkg::ChrLowX) begin
                  digits_d  = {number_i, 8'h00};
                  cnt_d     = 5'(pfe_pkg::HexDigits - 1);
                  started_d = 1'b0;
                  state_d   = ST_DIGIT;
                end else if (data_byte_i == pfe_pkg::ChrLowS) begin
                  smode_d = 1'b1;
                end else begin
                  emit = 1'b1;
                end
              end else if (data_byte_i == pfe_pkg::ChrPercent && !final_format_i) begin
                pending_d = 1'b1;
              end else begin
                emit = 1'b1;
              end
            end
            pfe_pkg::CmdStrByte: begin
              if (smode_q) begin
                if (data_byte_i == 8'h00) begin
                  smode_d = 1'b0;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            pfe_pkg::CmdStrEnd: begin
              smode_d = 1'b0;
            end
            pfe_pkg::CmdStrNull: begin
              if (smode_q) begin
                smode_d = 1'b0;
                cnt_d   = 5'(pfe_pkg::NullChars - 1);
                state_d = ST_NULL;
              end
            end
            default: ;
          endcase
        end
      end

      // One magnitude bit per cycle into the BCD register
      ST_CONV: begin
        digits_d = {bcd_adj[38:0], mag_q[31]};
        mag_d    = {mag_q[30:0], 1'b0};
        cnt_d    = cnt_q + 5'd1;
        if (cnt_q == 5'(pfe_pkg::NumBits - 1)) begin
          cnt_d     = 5'(pfe_pkg::DecDigits - 1);
          started_d = 1'b0;
          state_d   = ST_DIGIT;
        end
      end

      // One digit per cycle from the top while the output is not stalled, leading zeros skipped
      ST_DIGIT: begin
        emit_char = pfe_pkg::hex_char(top_dig);
        emit_last = (cnt_q == 5'd0);
        if (!show_dig || out_free) begin
          emit     = show_dig;
          digits_d = {digits_q[35:0], 4'h0};
          if (show_dig) begin
            started_d = 1'b1;
          end
          if (cnt_q == 5'd0) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - 5'd1;
          end
        end
      end

      ST_NULL: begin
        emit_char = pfe_pkg::null_char(cnt_q[2:0]);
        emit_last = (cnt_q == 5'd0);
        if (out_free) begin
          emit = 1'b1;
          if (cnt_q == 5'd0) begin
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - 5'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mag_q       <= '0;
      digits_q    <= '0;
      started_q   <= 1'b0;
      pending_q   <= 1'b0;
      smode_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mag_q       <= mag_d;
      digits_q    <= digits_d;
      started_q   <= started_d;
      pending_q   <= pending_d;
      smode_q     <= smode_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        out_char_q <= emit_char;
        out_last_q <= emit_last;
        if (!(&total_q)) begin
          total_q <= total_q + 31'd1;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = out_last_q;
  assign total_o     = total_q;

`ifndef SYNTHESIS
  // Count only moves up, one step per new character
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (total_o == $past(total_o) || total_o == $past(total_o) + 31'd1))
    else $error("character count jumped");

  // A pending '%' and string mode never coexist
  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pending_q && smode_q))
    else $error("pending percent inside string mode");

  // Once the last character of an item is shown, the sequencer is idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (state_q == ST_IDLE))
    else $error("last character shown while still busy");

  // No item is taken during a BCD conversion or a "(null)" run
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV || state_q == ST_NULL) |-> !accept)
    else $error("item accepted during a run");
`endif

endmodule
